// ===== src/m4ta_pkg.sv =====
package m4ta_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned N_ELEM = 16;

  localparam logic [4:0] TRANS_LAST = 5'd3;
  localparam logic [4:0] SWAP_LAST  = 5'd23;
  localparam logic [4:0] LOAD_LAST  = 5'd4;
  localparam logic [4:0] MAC_ISSUES = 5'd16;
  localparam logic [4:0] MAC_LAST   = 5'd17;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ACT_IDENT = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_LOAD  = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_TRANS = 3'd4,
    ACT_SCALE = 3'd5,
    ACT_SWAP  = 3'd6,
    ACT_READ  = 3'd7
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TRANS,
    ST_SWAP,
    ST_LOAD,
    ST_MAC,
    ST_FINISH
  } st_e;

  typedef struct packed {
    logic [31:0] value;
    logic        clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    logic ovf;
    ovf = (v[63:31] != {33{v[63]}});
    r.value = ovf ? (v[63] ? SAT_MIN : SAT_MAX) : v[31:0];
    r.clip = ovf;
    return r;
  endfunction

  // Lower and upper element of each off-diagonal pair exchanged by the transpose.
  function automatic logic [3:0] swap_lo(input logic [2:0] p);
    logic [3:0] a;
    case (p)
      3'd0: a = 4'd1;
      3'd1: a = 4'd2;
      3'd2: a = 4'd3;
      3'd3: a = 4'd6;
      3'd4: a = 4'd7;
      3'd5: a = 4'd11;
      default: a = 4'd0;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] swap_hi(input logic [2:0] p);
    logic [3:0] a;
    case (p)
      3'd0: a = 4'd4;
      3'd1: a = 4'd8;
      3'd2: a = 4'd12;
      3'd3: a = 4'd9;
      3'd4: a = 4'd13;
      3'd5: a = 4'd14;
      default: a = 4'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/mat4_transform_accumulator_top.sv =====
// Identity, element write and operand load: result in the cycle after the transfer, one per
// cycle unless the output stalls. Read, translate, transpose and multiply take the next
// transfer in the cycle their result appears, if the output is not stalled. Multiply and scale
// use the single shared multiply-accumulate unit; each of the four rows takes a row fetch,
// then its 16 products and the pipeline drain. Reset is asynchronous and active low; both
// matrices read as identity straight away through per-entry valid bits, with no clearing pass.
module mat4_transform_accumulator_top
  import m4ta_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  elem_index_i,
  input  logic [31:0] elem_value_i,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        saturated_o
);

  localparam logic [31:0] OneFx = 32'(64'd1 << FRAC_BITS);

  function automatic logic [31:0] ident_val(input logic [3:0] a);
    return (a[1:0] == a[3:2]) ? OneFx : '0;
  endfunction

  st_e         state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  row_q, row_d;
  logic [1:0]  km1;
  act_e        in_act, act_q;
  logic [31:0] vec_q [3];
  logic [15:0] acc_valid_q, op_valid_q;

  logic        acc_rd_ident_q, op_rd_ident_q;
  logic [3:0]  acc_rd_addr_q, op_rd_addr_q;
  logic [31:0] acc_rdata, op_rdata, acc_eff, op_eff;

  logic        acc_we, acc_re, op_we, op_re;
  logic [3:0]  acc_waddr, acc_raddr, op_waddr, op_raddr;
  logic [31:0] acc_wdata, op_wdata;

  logic [31:0] row_reg_q [4];
  logic [31:0] tmp_q, res_val_q;
  logic        res_sat_q, sat_hit;

  logic        mac_issue;
  logic        s1_valid_q, s2_valid_q;
  logic [1:0]  s1_k_q, s1_c_q, s2_k_q, s2_c_q;
  logic [31:0] vec_sel, diag_sel, b_val;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d, prod_q, sum_q, sum_new;
  sat_t        trans_sat, mac_sat;

  logic        in_accept, slot_free, simple_act, out_load;
  logic        out_valid_q, out_sat_q;
  logic [31:0] out_value_q;

  assign in_act     = act_e'(action_i);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign simple_act = (in_act == ACT_IDENT) || (in_act == ACT_WRITE) || (in_act == ACT_LOAD);
  assign out_load   = (in_accept && simple_act) || ((state_q == ST_FINISH) && slot_free);
  assign km1        = cnt_q[1:0] - 2'd1;

  m4ta_ram #(.WIDTH(ELEM_W), .DEPTH(N_ELEM)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  m4ta_ram #(.WIDTH(ELEM_W), .DEPTH(N_ELEM)) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (op_we),
    .waddr_i (op_waddr),
    .wdata_i (op_wdata),
    .re_i    (op_re),
    .raddr_i (op_raddr),
    .rdata_o (op_rdata)
  );

  assign acc_eff = acc_rd_ident_q ? ident_val(acc_rd_addr_q) : acc_rdata;
  assign op_eff  = op_rd_ident_q ? ident_val(op_rd_addr_q) : op_rdata;

  always_comb begin
    case (km1)
      2'd0: vec_sel = vec_q[0];
      2'd1: vec_sel = vec_q[1];
      default: vec_sel = vec_q[2];
    endcase
  end

  always_comb begin
    case (s1_k_q)
      2'd0: diag_sel = vec_q[0];
      2'd1: diag_sel = vec_q[1];
      2'd2: diag_sel = vec_q[2];
      default: diag_sel = OneFx;
    endcase
  end

  assign b_val = (act_q == ACT_MUL) ? op_eff : ((s1_k_q == s1_c_q) ? diag_sel : '0);
  assign mul_a = $signed(row_reg_q[s1_k_q]);
  assign mul_b = $signed(b_val);
  assign prod_d = mul_a * mul_b;
  assign sum_new = ((s2_k_q == 2'd0) ? 64'sd0 : sum_q) + (prod_q >>> FRAC_BITS);
  assign mac_sat = sat32(sum_new);
  assign trans_sat = sat32(64'($signed(acc_eff)) + 64'($signed(vec_sel)));
  assign mac_issue = (state_q == ST_MAC) && (cnt_q < MAC_ISSUES);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_act)
            ACT_READ:  state_d = ST_READ;
            ACT_TRANS: state_d = ST_TRANS;
            ACT_SWAP:  state_d = ST_SWAP;
            ACT_MUL:   state_d = ST_LOAD;
            ACT_SCALE: state_d = ST_LOAD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_FINISH;
      ST_TRANS: begin
        if (cnt_q == TRANS_LAST) state_d = ST_FINISH;
      end
      ST_SWAP: begin
        if (cnt_q == SWAP_LAST) state_d = ST_FINISH;
      end
      ST_LOAD: begin
        if (cnt_q == LOAD_LAST) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (cnt_q == MAC_LAST) state_d = (row_q == 2'd3) ? ST_FINISH : ST_LOAD;
      end
      ST_FINISH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cnt_d = (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
  assign row_d = in_accept ? 2'd0 :
                 ((state_q == ST_MAC) && (cnt_q == MAC_LAST)) ? row_q + 2'd1 : row_q;

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = '0;
    acc_wdata = '0;
    acc_re    = 1'b0;
    acc_raddr = '0;
    op_we     = 1'b0;
    op_waddr  = elem_index_i;
    op_wdata  = elem_value_i;
    op_re     = 1'b0;
    op_raddr  = cnt_q[3:0];
    sat_hit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_act)
            ACT_WRITE: begin
              acc_we    = 1'b1;
              acc_waddr = elem_index_i;
              acc_wdata = elem_value_i;
            end
            ACT_LOAD: op_we = 1'b1;
            ACT_READ: begin
              acc_re    = 1'b1;
              acc_raddr = elem_index_i;
            end
            default: ;
          endcase
        end
      end
      ST_TRANS: begin
        if (cnt_q < TRANS_LAST) begin
          acc_re    = 1'b1;
          acc_raddr = {2'b11, cnt_q[1:0]};
        end
        if (cnt_q != 5'd0) begin
          acc_we    = 1'b1;
          acc_waddr = {2'b11, km1};
          acc_wdata = trans_sat.value;
          sat_hit   = trans_sat.clip;
        end
      end
      ST_SWAP: begin
        case (cnt_q[1:0])
          2'd0: begin
            acc_re    = 1'b1;
            acc_raddr = swap_lo(cnt_q[4:2]);
          end
          2'd1: begin
            acc_re    = 1'b1;
            acc_raddr = swap_hi(cnt_q[4:2]);
          end
          2'd2: begin
            acc_we    = 1'b1;
            acc_waddr = swap_lo(cnt_q[4:2]);
            acc_wdata = acc_eff;
          end
          default: begin
            acc_we    = 1'b1;
            acc_waddr = swap_hi(cnt_q[4:2]);
            acc_wdata = tmp_q;
          end
        endcase
      end
      ST_LOAD: begin
        if (cnt_q < LOAD_LAST) begin
          acc_re    = 1'b1;
          acc_raddr = {cnt_q[1:0], row_q};
        end
      end
      ST_MAC: begin
        op_re = mac_issue && (act_q == ACT_MUL);
        if (s2_valid_q && (s2_k_q == 2'd3)) begin
          acc_we    = 1'b1;
          acc_waddr = {s2_c_q, row_q};
          acc_wdata = mac_sat.value;
          sat_hit   = mac_sat.clip;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      row_q       <= '0;
      acc_valid_q <= '0;
      op_valid_q  <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      row_q      <= row_d;
      s1_valid_q <= mac_issue;
      s2_valid_q <= s1_valid_q;
      if (in_accept && (in_act == ACT_IDENT)) begin
        acc_valid_q <= '0;
      end else if (acc_we) begin
        acc_valid_q[acc_waddr] <= 1'b1;
      end
      if (op_we) begin
        op_valid_q[op_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q     <= in_act;
      vec_q[0]  <= vec_x_i;
      vec_q[1]  <= vec_y_i;
      vec_q[2]  <= vec_z_i;
      res_sat_q <= 1'b0;
      res_val_q <= '0;
    end else begin
      if (sat_hit) res_sat_q <= 1'b1;
      if (state_q == ST_READ) res_val_q <= acc_eff;
    end
    if (acc_re) begin
      acc_rd_ident_q <= !acc_valid_q[acc_raddr];
      acc_rd_addr_q  <= acc_raddr;
    end
    if (op_re) begin
      op_rd_ident_q <= !op_valid_q[op_raddr];
      op_rd_addr_q  <= op_raddr;
    end
    if ((state_q == ST_SWAP) && (cnt_q[1:0] == 2'd1)) tmp_q <= acc_eff;
    if ((state_q == ST_LOAD) && (cnt_q != 5'd0)) row_reg_q[km1] <= acc_eff;
    if (mac_issue) begin
      s1_k_q <= cnt_q[1:0];
      s1_c_q <= cnt_q[3:2];
    end
    if (s1_valid_q) begin
      prod_q <= prod_d;
      s2_k_q <= s1_k_q;
      s2_c_q <= s1_c_q;
    end
    if (s2_valid_q) sum_q <= sum_new;
    if (out_load) begin
      out_value_q <= (state_q == ST_FINISH) ? res_val_q : '0;
      out_sat_q   <= (state_q == ST_FINISH) ? res_sat_q : 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign saturated_o  = out_sat_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_re && acc_we) |-> (acc_raddr != acc_waddr))
    else $error("accumulator read and write hit the same entry in one cycle");

  a_mac_drain_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MAC) && (cnt_q == MAC_LAST)) |->
      (s2_valid_q && (s2_k_q == 2'd3) && (s2_c_q == 2'd3)))
    else $error("multiply pipeline out of step with the row sequencer");

  a_ident_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_act == ACT_IDENT)) |=> (acc_valid_q == '0))
    else $error("identity did not clear the accumulator valid bits");

  a_s2_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (state_q == ST_MAC))
    else $error("multiply-accumulate stage active outside a multiply");

endmodule

// ===== src/m4ta_ram.sv =====
module m4ta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrWidth = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/mat4_transform_accumulator_top_tb.sv =====
module mat4_transform_accumulator_top_tb
  import m4ta_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [ELEM_W-1:0] FX_ONE = 32'd1 << FRAC;
  localparam logic [ELEM_W-1:0] FX_MAX = 32'h7fff_ffff;
  localparam logic [ELEM_W-1:0] FX_MIN = 32'h8000_0000;

  typedef struct packed {
    act_e              act;
    logic [ELEM_W-1:0] value;
    logic              sat;
  } result_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        action_i = ACT_READ;
  logic [3:0]        elem_index_i = '0;
  logic [ELEM_W-1:0] elem_value_i = '0;
  logic [ELEM_W-1:0] vec_x_i = '0;
  logic [ELEM_W-1:0] vec_y_i = '0;
  logic [ELEM_W-1:0] vec_z_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ELEM_W-1:0] read_value_o;
  logic              saturated_o;

  logic signed [ELEM_W-1:0] acc_m [N_ELEM];
  logic signed [ELEM_W-1:0] opd_m [N_ELEM];
  logic signed [ELEM_W-1:0] rhs_m [N_ELEM];

  result_t pending_q [$];
  int      errors = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      sat_results = 0;
  int      act_count [8];
  int      cycle_count = 0;
  bit      gap_mode = 1'b0;
  int      burst_left = 0;
  int      stall_mode = 0;
  int      hold_cycles = 0;

  mat4_transform_accumulator_top #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i(action_i),
    .elem_index_i(elem_index_i),
    .elem_value_i(elem_value_i),
    .vec_x_i(vec_x_i),
    .vec_y_i(vec_y_i),
    .vec_z_i(vec_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_value_o(read_value_o),
    .saturated_o(saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [ELEM_W-1:0] clip32(input longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return FX_MIN;
    end
    return v[ELEM_W-1:0];
  endfunction

  // The whole product is formed from the old accumulator before it is overwritten.
  function automatic void post_multiply(inout bit clipped);
    logic signed [ELEM_W-1:0] res [N_ELEM];
    longint sum;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) begin
          sum += (longint'(acc_m[r + 4 * k]) * longint'(rhs_m[k + 4 * c])) >>> FRAC;
        end
        res[r + 4 * c] = clip32(sum, clipped);
      end
    end
    acc_m = res;
  endfunction

  function automatic result_t predict_result(input act_e a, input logic [3:0] idx,
                                             input logic [ELEM_W-1:0] v, x, y, z);
    result_t r;
    bit clipped;
    logic signed [ELEM_W-1:0] t;
    clipped = 1'b0;
    r.act = a;
    r.value = '0;
    case (a)
      ACT_IDENT: begin
        for (int k = 0; k < N_ELEM; k++) acc_m[k] = (k % 5 == 0) ? FX_ONE : '0;
      end
      ACT_WRITE: acc_m[idx] = v;
      ACT_LOAD: opd_m[idx] = v;
      ACT_MUL: begin
        rhs_m = opd_m;
        post_multiply(clipped);
      end
      ACT_TRANS: begin
        acc_m[12] = clip32(longint'(acc_m[12]) + longint'($signed(x)), clipped);
        acc_m[13] = clip32(longint'(acc_m[13]) + longint'($signed(y)), clipped);
        acc_m[14] = clip32(longint'(acc_m[14]) + longint'($signed(z)), clipped);
      end
      ACT_SCALE: begin
        for (int k = 0; k < N_ELEM; k++) rhs_m[k] = (k % 5 == 0) ? FX_ONE : '0;
        rhs_m[0] = x;
        rhs_m[5] = y;
        rhs_m[10] = z;
        post_multiply(clipped);
      end
      ACT_SWAP: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = c + 1; r < 4; r++) begin
            t = acc_m[r + 4 * c];
            acc_m[r + 4 * c] = acc_m[c + 4 * r];
            acc_m[c + 4 * r] = t;
          end
        end
      end
      default: r.value = acc_m[idx];
    endcase
    r.sat = clipped;
    return r;
  endfunction

  // Mostly small values of a few units, with the extremes and full-range noise mixed in.
  function automatic logic [ELEM_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return FX_MAX;
          1: return FX_MIN;
          2: return FX_ONE;
          default: return -FX_ONE;
        endcase
      end
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic send_item(input act_e a, input logic [3:0] idx,
                           input logic [ELEM_W-1:0] v, x, y, z);
    result_t r;
    action_i <= a;
    elem_index_i <= idx;
    elem_value_i <= v;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_result(a, idx, v, x, y, z);
    pending_q.push_back(r);
    items_sent++;
    act_count[a]++;
    if (gap_mode) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12))
          @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_element_access();
    send_item(ACT_READ, 4'd0, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd5, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd1, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_WRITE, 4'd0, FX_MAX, $urandom, $urandom, $urandom);
    send_item(ACT_WRITE, 4'd15, FX_MIN, $urandom, $urandom, $urandom);
    send_item(ACT_WRITE, 4'd6, 32'd1, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd0, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd15, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd6, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_LOAD, 4'd3, FX_MIN, $urandom, $urandom, $urandom);
    send_item(ACT_LOAD, 4'd12, FX_MAX, $urandom, $urandom, $urandom);
    wait_for_results();
  endtask

  task automatic test_arithmetic_corners();
    send_item(ACT_IDENT, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_MUL, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd3, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_MUL, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd0, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_TRANS, 4'($urandom), $urandom, FX_MAX, FX_MAX, FX_MAX);
    send_item(ACT_TRANS, 4'($urandom), $urandom, FX_MIN, FX_MIN, FX_MIN);
    send_item(ACT_READ, 4'd12, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_SCALE, 4'($urandom), $urandom, FX_MIN, FX_MAX, 32'd0);
    send_item(ACT_READ, 4'd0, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_WRITE, 4'd1, 32'h0001_1111, $urandom, $urandom, $urandom);
    send_item(ACT_SWAP, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd4, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_READ, 4'd10, $urandom, $urandom, $urandom, $urandom);
    wait_for_results();
  endtask

  task automatic test_random_sequences();
    int stop_at;
    int n;
    act_e op;
    for (int phase = 0; phase < 4; phase++) begin
      gap_mode = (phase == 1) || (phase == 3);
      stall_mode = (phase == 2) ? 1 : ((phase == 3) ? 2 : 0);
      burst_left = $urandom_range(1, 16);
      stop_at = items_sent + 160;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 2) == 0)
            send_item(ACT_IDENT, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
          n = $urandom_range(1, 6);
          repeat (n) begin
            send_item(($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_LOAD, 4'($urandom),
                      rand_q16(), $urandom, $urandom, $urandom);
          end
          case ($urandom_range(0, 3))
            0: op = ACT_MUL;
            1: op = ACT_SCALE;
            2: op = ACT_TRANS;
            default: op = ACT_SWAP;
          endcase
          send_item(op, 4'($urandom), $urandom, rand_q16(), rand_q16(), rand_q16());
          n = $urandom_range(1, 4);
          repeat (n) send_item(ACT_READ, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
          send_item(act_e'($urandom_range(0, 7)), 4'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
        end
      end
      wait_for_results();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    int stop_at;
    gap_mode = 1'b0;
    stall_mode = 1;
    hold_cycles = 500;
    stop_at = items_sent + 80;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_item(ACT_MUL, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        1, 2, 3: send_item(ACT_WRITE, 4'($urandom), rand_q16(), $urandom, $urandom, $urandom);
        4, 5: send_item(ACT_LOAD, 4'($urandom), rand_q16(), $urandom, $urandom, $urandom);
        default: send_item(ACT_READ, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
      endcase
    end
    wait_for_results();
    stall_mode = 0;
  endtask

  initial begin
    for (int k = 0; k < N_ELEM; k++) begin
      acc_m[k] = (k % 5 == 0) ? FX_ONE : '0;
      opd_m[k] = (k % 5 == 0) ? FX_ONE : '0;
    end
    for (int k = 0; k < 8; k++) act_count[k] = 0;
  end

  initial begin
    int stall_tick;
    stall_tick = 0;
    forever begin
      @(posedge clk_i);
      stall_tick++;
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          1: out_stall_i <= ($urandom_range(0, 99) < 35);
          2: out_stall_i <= ((stall_tick % 11) < 4);
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got value %h saturated %b",
                   $time, read_value_o, saturated_o);
          errors++;
        end else begin
          want = pending_q.pop_front();
          results_checked++;
          if (want.sat) sat_results++;
          if (read_value_o !== want.value) begin
            $display("%0t ns: action %0d read_value expected %h, got %h",
                     $time, want.act, want.value, read_value_o);
            errors++;
          end
          if (saturated_o !== want.sat) begin
            $display("%0t ns: action %0d saturated expected %b, got %b",
                     $time, want.act, want.sat, saturated_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("%0t ns: run timed out with %0d results outstanding",
                 $time, pending_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_element_access();
    test_arithmetic_corners();
    test_random_sequences();
    test_output_backpressure();
    wait_for_results();
    repeat (120) @(posedge clk_i);
    $display("Run covered %0d transfers (%0d multiply, %0d scale, %0d translate, %0d transpose).",
             items_sent, act_count[ACT_MUL], act_count[ACT_SCALE], act_count[ACT_TRANS],
             act_count[ACT_SWAP]);
    $display("Checked %0d results, %0d of them saturating, with %0d errors in %0d cycles.",
             results_checked, sat_results, errors, cycle_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
